>>> rtl/core/opa_pkg.sv
// Shared types, codes and constants of the object pool allocator.
// No dependencies; used by object_pool_allocator_core.
package opa_pkg;

	// Defaults and fixed field widths.
	localparam int MAX_SLOTS   = 1024;
	localparam int ADDR_W      = 32;
	localparam int FLD_CNT_W   = 11;
	localparam int FLD_SLOT_W  = 10;
	localparam int OBJ_W       = 13;
	localparam int ALIGN_W     = 4;
	localparam int ALIGN_MAX   = 12;
	localparam int SZ_W        = 14;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	typedef enum logic [1:0] {
		FUNC_ALLOC = 2'd0,
		FUNC_FREE  = 2'd1,
		FUNC_GROW  = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_LIMIT     = 3'd1,
		ST_RESERVE   = 3'd2,
		ST_NOMEM     = 3'd3,
		ST_UNDERFLOW = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HEAP_BASE    = 3'd0,
		CFG_HEAP_BYTES   = 3'd1,
		CFG_OBJECT_BYTES = 3'd2,
		CFG_ALIGN_LOG2   = 3'd3,
		CFG_LIMIT_EN     = 3'd4,
		CFG_COUNT_LIMIT  = 3'd5,
		CFG_RESERVE_EN   = 3'd6,
		CFG_RESERVE      = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		func_t                  func;
		logic [FLD_SLOT_W-1:0]  slot_in;
		logic [FLD_CNT_W-1:0]   grow_count;
	} req_t;

	typedef struct packed {
		status_t                status;
		logic [FLD_SLOT_W-1:0]  slot_out;
		logic [ADDR_W-1:0]      address;
		logic [FLD_CNT_W-1:0]   granted;
		logic [FLD_CNT_W-1:0]   used_now;
		logic [FLD_CNT_W-1:0]   free_now;
		logic [FLD_CNT_W-1:0]   peak_now;
	} rsp_t;

	// Alignment mask with the exponent saturated at the largest supported value.
	function automatic logic [SZ_W-1:0] align_mask(input logic [ALIGN_W-1:0] a);
		logic [ALIGN_W-1:0] s;
		s = (a > ALIGN_W'(ALIGN_MAX)) ? ALIGN_W'(ALIGN_MAX) : a;
		return (SZ_W'(1) << s) - SZ_W'(1);
	endfunction

	// Slot size: object size (zero counts as one) rounded up to the alignment.
	function automatic logic [SZ_W-1:0] slot_size(input logic [OBJ_W-1:0] obj,
			input logic [ALIGN_W-1:0] a);
		logic [SZ_W-1:0] m;
		logic [SZ_W-1:0] b;
		m = align_mask(a);
		b = (obj == '0) ? SZ_W'(1) : SZ_W'(obj);
		return (b + m) & ~m;
	endfunction

endpackage

>>> rtl/core/opa_link_mem.sv
// Free-list link memory: one write port, one read port with registered data.
// No package dependencies.
module opa_link_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 11
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/core/object_pool_allocator_core.sv
// Object pool allocator top level: sequencer, shared multiplier, divider, pool state.
// Depends on opa_pkg and opa_link_mem.
//
//  channel | direction | handshake             | beat
//  req     | in        | req_valid/req_ready   | opa_pkg::req_t
//  rsp     | out       | rsp_valid/rsp_ready   | opa_pkg::rsp_t
//  cfg     | in        | cfg_we                | cfg_index, cfg_data
//
// From accept to a result beat, free passes S_FREE and S_FIN; allocate passes S_ACHK,
// S_APOP, S_AFIN and S_FIN. A grow for N slots granted runs a setup step, two multiplier
// passes, a radix-2 divider over the count bits, then one link memory write per slot.
// An allocate on an empty list runs the grow sequence for one slot first.
// Reset initialises the sequencer, configuration and pool state, not the link memory.
// The result register holds a beat until rsp_ready; req_ready is low while
// an item is in work or its result cannot be stored yet.
module object_pool_allocator_core #(
	parameter int MAX_SLOTS = opa_pkg::MAX_SLOTS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  opa_pkg::req_t                    req,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output opa_pkg::rsp_t                    rsp,
	input  logic                             cfg_we,
	input  logic [opa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [opa_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int CW      = $clog2(MAX_SLOTS + 1);
	localparam int IW      = $clog2(MAX_SLOTS);
	localparam int FCW     = opa_pkg::FLD_CNT_W;
	localparam int FSW     = opa_pkg::FLD_SLOT_W;
	localparam int AW      = opa_pkg::ADDR_W;
	localparam int SW      = opa_pkg::SZ_W;
	localparam int WIDE_W  = (CW > FCW) ? CW : FCW;
	localparam int PROD_W  = SW + CW;
	localparam int DIV_W   = AW + CW;
	localparam int KW      = $clog2(CW);

	typedef enum logic [11:0] {
		S_IDLE   = 12'b000000000001,
		S_ACHK   = 12'b000000000010,
		S_APOP   = 12'b000000000100,
		S_AFIN   = 12'b000000001000,
		S_FREE   = 12'b000000010000,
		S_GSETUP = 12'b000000100000,
		S_GMUL   = 12'b000001000000,
		S_GDIV   = 12'b000010000000,
		S_GCARVE = 12'b000100000000,
		S_GUPD   = 12'b001000000000,
		S_GLINK  = 12'b010000000000,
		S_FIN    = 12'b100000000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [AW-1:0]                heap_base_q, heap_bytes_q, reserve_bytes_q;
	logic [opa_pkg::OBJ_W-1:0]    object_bytes_q;
	logic [opa_pkg::ALIGN_W-1:0]  align_log2_q;
	logic                         limit_en_q, reserve_en_q;
	logic [FCW-1:0]               count_limit_q;

	// Pool state.
	logic [CW-1:0]  head_q, used_q, free_q, peak_q, carved_q, cap_count_q;
	logic [AW-1:0]  origin_q, cursor_q, remain_q;
	logic           cap_valid_q;

	// Item and sequencer registers.
	logic           from_alloc_q, req_nz_q;
	logic [FSW-1:0] slot_in_q;
	logic [FCW-1:0] grow_count_q;
	logic [CW-1:0]  req_eff_q, quot_q, n_q, first_q, old_head_q, link_i_q;
	logic [AW-1:0]  start_q, end_q, room_q, rem_q;
	logic [KW-1:0]  div_k_q;
	logic [PROD_W-1:0] prod_q;

	// Result registers.
	opa_pkg::status_t res_status_q;
	logic [CW-1:0]    res_slot_q, res_granted_q;
	logic [AW-1:0]    res_addr_q;
	opa_pkg::rsp_t    rsp_q;
	logic             rsp_valid_q;

	// Link memory ports.
	logic          lm_we, lm_re;
	logic [IW-1:0] lm_waddr;
	logic [CW-1:0] lm_wdata, lm_rdata;

	logic [SW-1:0]     sz;
	logic [AW-1:0]     mask_a;
	logic [AW-1:0]     start_c, end_c;
	logic [CW-1:0]     avail_c, req_eff_c, n_c;
	logic [CW-1:0]     mul_b;
	logic              mul_en;
	logic [DIV_W-1:0]  dvs;
	logic              div_ge;
	logic              grow_end;
	logic [CW-1:0]     grow_n;
	logic              cap_valid_c;
	logic [CW-1:0]     cap_count_c;
	logic              free_ok;
	logic [CW-1:0]     used_inc;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Slot geometry and carving window.
	assign sz      = opa_pkg::slot_size(object_bytes_q, align_log2_q);
	assign mask_a  = AW'(opa_pkg::align_mask(align_log2_q));
	assign start_c = (cursor_q + mask_a) & ~mask_a;
	assign end_c   = heap_base_q + heap_bytes_q;
	assign avail_c = CW'(MAX_SLOTS) - carved_q;
	assign req_eff_c = (WIDE_W'(grow_count_q) > WIDE_W'(avail_c)) ? avail_c
		: CW'(grow_count_q);

	// Shared multiplier operand select.
	always_comb begin
		mul_en = 1'b1;
		unique case (state_q)
			S_GMUL:   mul_b = req_eff_q;
			S_GCARVE: mul_b = n_c;
			S_APOP:   mul_b = head_q;
			default: begin
				mul_b  = '0;
				mul_en = 1'b0;
			end
		endcase
	end

	// One restoring divider step, most significant quotient bit first.
	assign dvs    = DIV_W'(sz) << div_k_q;
	assign div_ge = DIV_W'(rem_q) >= dvs;

	// Whole request if it fits, otherwise the whole objects left in the room.
	assign n_c = (room_q >= AW'(prod_q)) ? req_eff_q : quot_q;

	// End of a grow sequence and its slot count.
	always_comb begin
		grow_end = 1'b0;
		grow_n   = '0;
		unique case (state_q)
			S_GSETUP: grow_end = (start_c > end_c) || (req_eff_c == '0);
			S_GCARVE: grow_end = (n_c == '0);
			S_GLINK: begin
				grow_end = (link_i_q == n_q - CW'(1));
				grow_n   = n_q;
			end
			default: grow_end = 1'b0;
		endcase
	end

	// Reserve cap latch as the allocate check sees it.
	always_comb begin
		cap_valid_c = cap_valid_q;
		cap_count_c = cap_count_q;
		if (reserve_en_q) begin
			if (!cap_valid_q) begin
				if (remain_q <= reserve_bytes_q) begin
					cap_valid_c = 1'b1;
					cap_count_c = used_q + free_q;
				end
			end else if (remain_q > reserve_bytes_q) begin
				cap_valid_c = 1'b0;
			end
		end
	end

	assign free_ok  = (used_q != '0) && (WIDE_W'(slot_in_q) < WIDE_W'(carved_q));
	assign used_inc = used_q + CW'(1);

	// Link memory access.
	always_comb begin
		lm_we    = 1'b0;
		lm_waddr = '0;
		lm_wdata = '0;
		if (state_q == S_FREE && free_ok) begin
			lm_we    = 1'b1;
			lm_waddr = IW'(slot_in_q);
			lm_wdata = head_q;
		end else if (state_q == S_GLINK) begin
			lm_we    = 1'b1;
			lm_waddr = IW'(first_q + link_i_q);
			lm_wdata = (link_i_q + CW'(1) < n_q) ? first_q + link_i_q + CW'(1) : old_head_q;
		end
	end
	assign lm_re = (state_q == S_APOP);

	opa_link_mem #(
		.DEPTH (MAX_SLOTS),
		.WIDTH (CW)
	) u_link_mem (
		.clk     (clk),
		.wr_en   (lm_we),
		.wr_addr (lm_waddr),
		.wr_data (lm_wdata),
		.rd_en   (lm_re),
		.rd_addr (IW'(head_q)),
		.rd_data (lm_rdata)
	);

	// Shared multiplier with registered product.
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= PROD_W'(sz) * PROD_W'(mul_b);
		end
	end

	// Sequencer, pool state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			heap_base_q    <= '0;
			heap_bytes_q   <= '0;
			reserve_bytes_q <= '0;
			object_bytes_q <= opa_pkg::OBJ_W'(1);
			align_log2_q   <= '0;
			limit_en_q     <= 1'b0;
			count_limit_q  <= FCW'(1024);
			reserve_en_q   <= 1'b0;
			head_q         <= CW'(MAX_SLOTS);
			used_q         <= '0;
			free_q         <= '0;
			peak_q         <= '0;
			carved_q       <= '0;
			origin_q       <= '0;
			cursor_q       <= '0;
			remain_q       <= '0;
			cap_valid_q    <= 1'b0;
			cap_count_q    <= '0;
			rsp_valid_q    <= 1'b0;
			from_alloc_q   <= 1'b0;
		end else begin
			// A taken beat empties the result register unless a new one is loaded.
			if (rsp_valid_q && rsp_ready && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						slot_in_q     <= req.slot_in;
						grow_count_q  <= req.grow_count;
						req_nz_q      <= (req.grow_count != '0);
						res_status_q  <= opa_pkg::ST_OK;
						res_slot_q    <= '0;
						res_addr_q    <= '0;
						res_granted_q <= '0;
						from_alloc_q  <= 1'b0;
						unique case (req.func)
							opa_pkg::FUNC_ALLOC: state_q <= S_ACHK;
							opa_pkg::FUNC_FREE:  state_q <= S_FREE;
							opa_pkg::FUNC_GROW:  state_q <= S_GSETUP;
							default:             state_q <= S_FIN;
						endcase
					end
				end
				S_ACHK: begin
					if (limit_en_q && WIDE_W'(used_q) >= WIDE_W'(count_limit_q)) begin
						res_status_q <= opa_pkg::ST_LIMIT;
						state_q      <= S_FIN;
					end else begin
						cap_valid_q <= cap_valid_c;
						cap_count_q <= cap_count_c;
						if (reserve_en_q && cap_valid_c && used_q >= cap_count_c) begin
							res_status_q <= opa_pkg::ST_RESERVE;
							state_q      <= S_FIN;
						end else if (free_q == '0) begin
							from_alloc_q <= 1'b1;
							grow_count_q <= FCW'(1);
							state_q      <= S_GSETUP;
						end else begin
							state_q <= S_APOP;
						end
					end
				end
				S_APOP: begin
					if (head_q >= CW'(MAX_SLOTS)) begin
						res_status_q <= opa_pkg::ST_NOMEM;
						state_q      <= S_FIN;
					end else begin
						res_slot_q <= head_q;
						state_q    <= S_AFIN;
					end
				end
				S_AFIN: begin
					head_q     <= lm_rdata;
					used_q     <= used_inc;
					free_q     <= free_q - CW'(1);
					if (used_inc > peak_q) begin
						peak_q <= used_inc;
					end
					res_addr_q <= origin_q + AW'(prod_q);
					state_q    <= S_FIN;
				end
				S_FREE: begin
					if (free_ok) begin
						head_q <= CW'(slot_in_q);
						free_q <= free_q + CW'(1);
						used_q <= used_q - CW'(1);
					end else begin
						res_status_q <= opa_pkg::ST_UNDERFLOW;
					end
					state_q <= S_FIN;
				end
				S_GSETUP: begin
					start_q   <= start_c;
					end_q     <= end_c;
					room_q    <= end_c - start_c;
					rem_q     <= end_c - start_c;
					req_eff_q <= req_eff_c;
					if (!grow_end) begin
						state_q <= S_GMUL;
					end
				end
				S_GMUL: begin
					div_k_q <= KW'(CW - 1);
					quot_q  <= '0;
					state_q <= S_GDIV;
				end
				S_GDIV: begin
					if (div_ge) begin
						rem_q <= rem_q - AW'(dvs);
					end
					quot_q <= {quot_q[CW-2:0], div_ge};
					if (div_k_q == '0) begin
						state_q <= S_GCARVE;
					end else begin
						div_k_q <= div_k_q - KW'(1);
					end
				end
				S_GCARVE: begin
					n_q     <= n_c;
					if (!grow_end) begin
						state_q <= S_GUPD;
					end
				end
				S_GUPD: begin
					if (carved_q == '0) begin
						origin_q <= start_q;
					end
					cursor_q   <= start_q + AW'(prod_q);
					remain_q   <= end_q - (start_q + AW'(prod_q));
					first_q    <= carved_q;
					old_head_q <= head_q;
					head_q     <= carved_q;
					free_q     <= free_q + n_q;
					carved_q   <= carved_q + n_q;
					link_i_q   <= '0;
					state_q    <= S_GLINK;
				end
				S_GLINK: begin
					link_i_q <= link_i_q + CW'(1);
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q.status   <= res_status_q;
						rsp_q.slot_out <= FSW'(res_slot_q);
						rsp_q.address  <= res_addr_q;
						rsp_q.granted  <= FCW'(res_granted_q);
						rsp_q.used_now <= FCW'(used_q);
						rsp_q.free_now <= FCW'(free_q);
						rsp_q.peak_now <= FCW'(peak_q);
						rsp_valid_q    <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// Finish of a grow: report it, or carry on with the allocate.
			if (grow_end) begin
				if (from_alloc_q) begin
					if (grow_n == '0) begin
						res_status_q <= opa_pkg::ST_NOMEM;
						state_q      <= S_FIN;
					end else begin
						state_q <= S_APOP;
					end
				end else begin
					res_granted_q <= grow_n;
					if (grow_n == '0 && req_nz_q) begin
						res_status_q <= opa_pkg::ST_NOMEM;
					end
					state_q <= S_FIN;
				end
			end

			// Register writes; the region registers also reset the carving cursor and remaining bytes.
			if (cfg_we) begin
				unique case (opa_pkg::cfg_idx_t'(cfg_index))
					opa_pkg::CFG_HEAP_BASE: begin
						heap_base_q <= cfg_data;
						cursor_q    <= cfg_data;
					end
					opa_pkg::CFG_HEAP_BYTES: begin
						heap_bytes_q <= cfg_data;
						remain_q     <= cfg_data;
					end
					opa_pkg::CFG_OBJECT_BYTES: object_bytes_q <= cfg_data[opa_pkg::OBJ_W-1:0];
					opa_pkg::CFG_ALIGN_LOG2:   align_log2_q   <= cfg_data[opa_pkg::ALIGN_W-1:0];
					opa_pkg::CFG_LIMIT_EN:     limit_en_q     <= cfg_data[0];
					opa_pkg::CFG_COUNT_LIMIT:  count_limit_q  <= cfg_data[FCW-1:0];
					opa_pkg::CFG_RESERVE_EN:   reserve_en_q   <= cfg_data[0];
					opa_pkg::CFG_RESERVE:      reserve_bytes_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Every carved slot is either in use or on the free list.
	a_slot_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q + free_q) == carved_q)
		else $error("used plus free differs from carved slots");

	// The peak never trails the in-use count.
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= used_q)
		else $error("peak below in-use count");

	// Carving never passes the slot capacity.
	a_carved_max: assert property (@(posedge clk) disable iff (!arst_n)
		carved_q <= CW'(MAX_SLOTS))
		else $error("carved slots beyond capacity");

	// A new result beat only follows the finishing state.
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_FIN))
		else $error("result beat without a finished item");

endmodule
